### sv/rsst_pkg.sv
`default_nettype none

package rsst_pkg;

   localparam int LEAVES    = 1024;
   localparam int LEAF_BITS = $clog2(LEAVES);
   localparam int NODES     = 2 * LEAVES;
   localparam int NODE_BITS = LEAF_BITS + 1;
   localparam int WALK_BITS = NODE_BITS + 1;
   localparam int SIZE_BITS = LEAF_BITS + 1;
   localparam int SUM_BITS  = 32;
   localparam int REQ_BITS  = 64;
   localparam int CSR_ABITS = 3;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [CSR_ABITS-1:0] CSR_ACTIVE_SIZE = CSR_ABITS'(0);

   localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(LEAVES);

   typedef struct packed {
      logic                 wr_en;
      logic                 rd_en;
      logic [NODE_BITS-1:0] addr;
      logic [SUM_BITS-1:0]  wdata;
   } ram_req_type;

endpackage

`default_nettype wire

### sv/rsst_node_ram.sv
`default_nettype none

module rsst_node_ram (
   input  wire                                clock,
   input  rsst_pkg::ram_req_type              ram_req,
   output logic [rsst_pkg::SUM_BITS-1:0]      rd_data_ff
);

   logic [rsst_pkg::SUM_BITS-1:0] mem [rsst_pkg::NODES];

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.addr] <= ram_req.wdata;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.addr];
      end
   end

endmodule

`default_nettype wire

### sv/rsst_ctrl.sv
`default_nettype none

module rsst_ctrl (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   clear_start,
   input  wire  [rsst_pkg::SIZE_BITS-1:0]        active_size,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire                                   req_opcode,
   input  wire  [rsst_pkg::LEAF_BITS-1:0]        req_leaf_index,
   input  wire  [rsst_pkg::SUM_BITS-1:0]         req_add_value,
   input  wire  [rsst_pkg::LEAF_BITS-1:0]        req_range_low,
   input  wire  [rsst_pkg::LEAF_BITS-1:0]        req_range_high,
   output logic                                  rsp_valid_ff,
   input  wire                                   rsp_ready,
   output logic [rsst_pkg::SUM_BITS-1:0]         rsp_data_ff,
   output rsst_pkg::ram_req_type                 ram_req,
   input  wire  [rsst_pkg::SUM_BITS-1:0]         ram_rd_data
);

   typedef enum logic [2:0] {
      S_CLR, S_IDLE, S_AR, S_AW, S_QA, S_QB, S_DONE
   } state_type;

   state_type                           state_ff, state_in;
   logic [rsst_pkg::NODE_BITS-1:0]      ptr_ff, ptr_in;
   logic [rsst_pkg::WALK_BITS-1:0]      a_ff, a_in, b_ff, b_in, b_dec;
   logic [rsst_pkg::SUM_BITS-1:0]       acc_ff, acc_in, value_ff, value_in, sum;
   logic                                pend_ff, pend_in;
   logic                                rsp_valid_in;
   logic [rsst_pkg::SUM_BITS-1:0]       rsp_data_in;
   logic [rsst_pkg::SIZE_BITS-1:0]      eff_size;
   logic [rsst_pkg::LEAF_BITS-1:0]      last_leaf, leaf_clip, high_clip;

   always_comb begin
      if (active_size == '0) begin
         eff_size = rsst_pkg::SIZE_BITS'(1);
      end else if (active_size > rsst_pkg::SIZE_BITS'(rsst_pkg::LEAVES)) begin
         eff_size = rsst_pkg::SIZE_BITS'(rsst_pkg::LEAVES);
      end else begin
         eff_size = active_size;
      end
   end

   assign last_leaf = rsst_pkg::LEAF_BITS'(eff_size - rsst_pkg::SIZE_BITS'(1));
   assign leaf_clip = ({1'b0, req_leaf_index} >= eff_size) ? last_leaf : req_leaf_index;
   assign high_clip = ({1'b0, req_range_high} >= eff_size) ? last_leaf : req_range_high;

   // shared adder: leaf/ancestor update or query accumulate
   assign sum = ram_rd_data + ((state_ff == S_AW) ? value_ff : acc_ff);

   assign req_ready = (state_ff == S_IDLE);
   assign b_dec     = b_ff - rsst_pkg::WALK_BITS'(1);

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      value_in     = value_ff;
      pend_in      = 1'b0;
      acc_in       = pend_ff ? sum : acc_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      ram_req      = '0;

      case (state_ff)
         S_CLR: begin
            ram_req.wr_en = 1'b1;
            ram_req.addr  = ptr_ff;
            ptr_in        = ptr_ff + rsst_pkg::NODE_BITS'(1);
            if (ptr_ff == rsst_pkg::NODE_BITS'(rsst_pkg::NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               if (req_opcode == rsst_pkg::OP_ADD) begin
                  ptr_in   = {1'b1, leaf_clip};
                  value_in = req_add_value;
                  state_in = S_AR;
               end else begin
                  a_in     = {2'b01, req_range_low};
                  b_in     = {2'b01, high_clip} + rsst_pkg::WALK_BITS'(1);
                  acc_in   = '0;
                  state_in = S_QA;
               end
            end
         end
         S_AR: begin
            ram_req.rd_en = 1'b1;
            ram_req.addr  = ptr_ff;
            state_in      = S_AW;
         end
         S_AW: begin
            ram_req.wr_en = 1'b1;
            ram_req.addr  = ptr_ff;
            ram_req.wdata = sum;
            ptr_in        = ptr_ff >> 1;
            state_in      = (ptr_ff == rsst_pkg::NODE_BITS'(1)) ? S_IDLE : S_AR;
         end
         S_QA: begin
            if (a_ff >= b_ff) begin
               state_in = S_DONE;
            end else begin
               if (a_ff[0]) begin
                  ram_req.rd_en = 1'b1;
                  ram_req.addr  = a_ff[rsst_pkg::NODE_BITS-1:0];
                  a_in          = a_ff + rsst_pkg::WALK_BITS'(1);
                  pend_in       = 1'b1;
               end
               state_in = S_QB;
            end
         end
         S_QB: begin
            a_in = a_ff >> 1;
            if (b_ff[0]) begin
               ram_req.rd_en = 1'b1;
               ram_req.addr  = b_dec[rsst_pkg::NODE_BITS-1:0];
               pend_in       = 1'b1;
               b_in          = b_dec >> 1;
            end else begin
               b_in = b_ff >> 1;
            end
            state_in = S_QA;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = acc_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLR;
            ptr_in   = '0;
         end
      endcase

      if (clear_start) begin
         state_in = S_CLR;
         ptr_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff        <= a_in;
      b_ff        <= b_in;
      acc_ff      <= acc_in;
      value_ff    <= value_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

### sv/range_sum_segment_tree.sv
// Point-add / range-sum segment tree over 1024 leaves of 32-bit wrapped sums.
// Input beats (req_*): tuser is the opcode (0 add, 1 query). An add walks the
// leaf and its ten ancestors, one read and one write per node on the single
// node RAM port, and gives no result. A query walks the tree bottom-up with
// up to two node reads per level, then one rsp beat carrying the sum. The
// single RAM port and the one shared adder set the pace of both walks;
// req_tready is high only while the sequencer is idle.
// rsp_* holds the result in an output register, so a new request is taken
// while a result still waits; if rsp_tready stays low, the next query stalls
// at its end until the register is free.
// csr register 0 (byte address 0) is active_size, 11 bits, reset 1024.
// Reset and every write of active_size start a clearing pass that zeroes the
// node RAM, one word a cycle, with req_tready low meanwhile.
`default_nettype none

module range_sum_segment_tree (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // [9:0] leaf_index, [41:10] add_value, [51:42] range_low,
   // [61:52] range_high, [63:62] zero
   input  wire  [rsst_pkg::REQ_BITS-1:0]       req_tdata,
   // [0] opcode
   input  wire                                 req_tuser,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // [31:0] range_sum
   output logic [rsst_pkg::SUM_BITS-1:0]       rsp_tdata,
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [rsst_pkg::CSR_ABITS-1:0]      csr_paddr,
   input  wire  [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   logic [rsst_pkg::SIZE_BITS-1:0] size_ff, size_in;
   logic                           cfg_wr;
   logic                           sel_size;
   rsst_pkg::ram_req_type          ram_req;
   logic [rsst_pkg::SUM_BITS-1:0]  ram_rd_data;

   assign csr_pready = 1'b1;
   assign sel_size   = (csr_paddr[2] == rsst_pkg::CSR_ACTIVE_SIZE[2]);
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready & sel_size;
   assign size_in    = cfg_wr ? csr_pwdata[rsst_pkg::SIZE_BITS-1:0] : size_ff;
   assign csr_prdata = sel_size ?
                       {{(32 - rsst_pkg::SIZE_BITS){1'b0}}, size_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= rsst_pkg::SIZE_RESET;
      end else begin
         size_ff <= size_in;
      end
   end

   rsst_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .clear_start    (cfg_wr),
      .active_size    (size_ff),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_opcode     (req_tuser),
      .req_leaf_index (req_tdata[9:0]),
      .req_add_value  (req_tdata[41:10]),
      .req_range_low  (req_tdata[51:42]),
      .req_range_high (req_tdata[61:52]),
      .rsp_valid_ff   (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_data_ff    (rsp_tdata),
      .ram_req        (ram_req),
      .ram_rd_data    (ram_rd_data)
   );

   rsst_node_ram u_ram (
      .clock      (clock),
      .ram_req    (ram_req),
      .rd_data_ff (ram_rd_data)
   );

endmodule

`default_nettype wire

### sim/tb_range_sum_segment_tree.sv
`timescale 1ns / 1ps

module tb_range_sum_segment_tree;

   localparam int CYCLE_LIMIT  = 500_000;
   localparam int IDLE_PCT     = 17;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_BEATS  = 120;

   localparam logic [rsst_pkg::CSR_ABITS-1:0] CSR_SPARE = 3'd4;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type                      kind;
      logic                              op;
      logic [rsst_pkg::LEAF_BITS-1:0]    leaf;
      logic [31:0]                       value;
      logic [rsst_pkg::LEAF_BITS-1:0]    lo;
      logic [rsst_pkg::LEAF_BITS-1:0]    hi;
      logic [rsst_pkg::CSR_ABITS-1:0]    addr;
      logic                              fixed;
      logic [rsst_pkg::SUM_BITS-1:0]     sum;
   } stim_row_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   // [9:0] leaf_index, [41:10] add_value, [51:42] range_low,
   // [61:52] range_high, [63:62] zero
   logic [rsst_pkg::REQ_BITS-1:0]       req_tdata = '0;
   // [0] opcode
   logic                                req_tuser = rsst_pkg::OP_ADD;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   // [31:0] range_sum
   logic [rsst_pkg::SUM_BITS-1:0]       rsp_tdata;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [rsst_pkg::CSR_ABITS-1:0]      csr_paddr = '0;
   logic [31:0]                         csr_pwdata = '0;
   logic [31:0]                         csr_prdata;
   logic                                csr_pready;

   range_sum_segment_tree dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predicted leaf values and size register
   logic [rsst_pkg::SUM_BITS-1:0]   leaf_totals [rsst_pkg::LEAVES];
   logic [rsst_pkg::SIZE_BITS-1:0]  size_reg;
   logic [rsst_pkg::SUM_BITS-1:0]   pending_sums [$];
   stim_row_type                    plan [$];

   int  errors = 0;
   int  adds = 0;
   int  queries = 0;
   int  sums_checked = 0;
   int  size_writes = 0;
   int  cycles = 0;
   bit  calm = 1'b0;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d sums pending", cycles, pending_sums.size());
         $display("range_sum_segment_tree regression: fail");
         $finish;
      end
   end

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= 40)
         $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycles);
   endtask

   function automatic int unsigned live_leaves();
      if (size_reg == 0) return 1;
      if (size_reg > rsst_pkg::LEAVES) return rsst_pkg::LEAVES;
      return size_reg;
   endfunction

   task automatic clear_tree();
      foreach (leaf_totals[i]) leaf_totals[i] = '0;
   endtask

   function automatic logic [rsst_pkg::SUM_BITS-1:0] range_total(int unsigned lo,
                                                                  int unsigned hi);
      logic [rsst_pkg::SUM_BITS-1:0] total;
      int unsigned                   n;
      total = '0;
      n = live_leaves();
      if (hi >= n) hi = n - 1;
      if (lo <= hi)
         for (int unsigned i = lo; i <= hi; i++) total += leaf_totals[i];
      return total;
   endfunction

   function automatic stim_row_type beat_row(logic op, int unsigned leaf, logic [31:0] value,
                                             int unsigned lo, int unsigned hi,
                                             int unsigned fixed, logic [31:0] sum);
      stim_row_type r;
      r.kind = ROW_BEAT;
      r.op = op;
      r.leaf = rsst_pkg::LEAF_BITS'(leaf);
      r.value = value;
      r.lo = rsst_pkg::LEAF_BITS'(lo);
      r.hi = rsst_pkg::LEAF_BITS'(hi);
      r.addr = rsst_pkg::CSR_ACTIVE_SIZE;
      r.fixed = (fixed != 0);
      r.sum = sum;
      return r;
   endfunction

   function automatic stim_row_type csr_row(logic [rsst_pkg::CSR_ABITS-1:0] addr,
                                            logic [31:0] data);
      stim_row_type r;
      r = beat_row(rsst_pkg::OP_ADD, 0, data, 0, 0, 0, '0);
      r.kind = ROW_CSR;
      r.addr = addr;
      return r;
   endfunction

   task automatic add_row(stim_row_type r);
      plan = {plan, r};
   endtask

   task automatic send_beat(logic op, logic [9:0] leaf, logic [31:0] value,
                            logic [9:0] lo, logic [9:0] hi, logic fixed, logic [31:0] sum);
      int unsigned n;
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {2'b00, hi, lo, value, leaf};
      do @(posedge clock); while (!req_tready);
      n = live_leaves();
      if (op == rsst_pkg::OP_QUERY) begin
         queries++;
         pending_sums = {pending_sums, (fixed ? sum : range_total(lo, hi))};
      end else begin
         adds++;
         if (leaf >= n) leaf = rsst_pkg::LEAF_BITS'(n - 1);
         leaf_totals[leaf] += value;
      end
   endtask

   task automatic csr_access(logic wr, logic [rsst_pkg::CSR_ABITS-1:0] addr,
                             logic [31:0] data, output logic [31:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // quiesce, then write; adds leave no trace, so wait out their walk as well
   task automatic write_register(logic [rsst_pkg::CSR_ABITS-1:0] addr, logic [31:0] data);
      logic [31:0] rd;
      req_tvalid <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_access(1'b1, addr, data, rd);
      if (addr == rsst_pkg::CSR_ACTIVE_SIZE) begin
         size_reg = data[rsst_pkg::SIZE_BITS-1:0];
         clear_tree();
         size_writes++;
         csr_access(1'b0, rsst_pkg::CSR_ACTIVE_SIZE, '0, rd);
         if (rd !== 32'(size_reg)) report("active_size readback", rd, 32'(size_reg));
      end
   endtask

   task automatic random_beat();
      logic [63:0]  raw;
      int unsigned  n;
      logic         op;
      logic [9:0]   leaf;
      logic [9:0]   lo;
      logic [9:0]   hi;
      logic [31:0]  value;
      raw = {$urandom, $urandom};
      n = live_leaves();
      op = 1'($urandom_range(1));
      leaf = raw[9:0];
      value = raw[41:10];
      lo = raw[51:42];
      hi = raw[61:52];
      if (op == rsst_pkg::OP_ADD) begin
         if ($urandom_range(99) < 75) leaf = 10'($urandom_range(n - 1));
         case ($urandom_range(7))
            0: value = 32'h7fff_ffff;
            1: value = 32'h8000_0000;
            2: value = 32'hffff_ffff;
            3: value = $urandom_range(15);
            default: ;
         endcase
      end else if ($urandom_range(99) < 80) begin
         lo = 10'($urandom_range(n - 1));
         hi = 10'($urandom_range(n - 1));
         if (lo > hi && $urandom_range(3) != 0) {lo, hi} = {hi, lo};
      end
      send_beat(op, leaf, value, lo, hi, 1'b0, '0);
   endtask

   always @(posedge clock) begin : rsp_sink
      logic [rsst_pkg::SUM_BITS-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_sums.size() == 0) begin
            report("unexpected rsp beat", rsp_tdata, 'x);
         end else begin
            want = pending_sums.pop_front();
            sums_checked++;
            if (rsp_tdata !== want) report("range_sum", rsp_tdata, want);
         end
      end
      rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   initial begin : main
      int unsigned phase_sizes [9];
      logic [31:0] wdata;
      phase_sizes = '{1024, 1, 2, 3, 37, 0, 1023, 2047, 0};
      phase_sizes[8] = $urandom_range(2047, 1);
      size_reg = rsst_pkg::SIZE_RESET;
      clear_tree();

      add_row(beat_row(rsst_pkg::OP_QUERY, 0, 0, 0, 1023, 1, 32'h0000_0000));
      add_row(beat_row(rsst_pkg::OP_ADD, 0, 32'h7fff_ffff, 0, 0, 0, 0));
      add_row(beat_row(rsst_pkg::OP_ADD, 1023, 32'h0000_0001, 0, 0, 0, 0));
      add_row(beat_row(rsst_pkg::OP_QUERY, 0, 0, 0, 1023, 1, 32'h8000_0000));
      add_row(beat_row(rsst_pkg::OP_ADD, 512, 32'h8000_0000, 0, 0, 0, 0));
      add_row(beat_row(rsst_pkg::OP_QUERY, 0, 0, 0, 1023, 1, 32'h0000_0000));
      add_row(beat_row(rsst_pkg::OP_QUERY, 0, 0, 512, 512, 1, 32'h8000_0000));
      add_row(beat_row(rsst_pkg::OP_QUERY, 0, 0, 1023, 0, 1, 32'h0000_0000));
      add_row(beat_row(rsst_pkg::OP_QUERY, 0, 0, 1023, 1023, 1, 32'h0000_0001));
      // unused fields all ones
      add_row(beat_row(rsst_pkg::OP_ADD, 5, 32'hffff_ffff, 1023, 1023, 0, 0));
      add_row(beat_row(rsst_pkg::OP_QUERY, 1023, 32'hffff_ffff, 0, 10, 1, 32'h7fff_fffe));
      add_row(beat_row(rsst_pkg::OP_QUERY, 0, 0, 3, 7, 0, 0));
      add_row(csr_row(rsst_pkg::CSR_ACTIVE_SIZE, 1));
      add_row(beat_row(rsst_pkg::OP_ADD, 1023, 32'd9, 0, 0, 0, 0));
      add_row(beat_row(rsst_pkg::OP_QUERY, 0, 0, 0, 1023, 1, 32'd9));
      add_row(beat_row(rsst_pkg::OP_QUERY, 0, 0, 1, 1023, 1, 32'd0));
      add_row(csr_row(rsst_pkg::CSR_ACTIVE_SIZE, 0));
      add_row(beat_row(rsst_pkg::OP_ADD, 700, 32'd3, 0, 0, 0, 0));
      add_row(beat_row(rsst_pkg::OP_QUERY, 0, 0, 0, 0, 1, 32'd3));
      add_row(csr_row(CSR_SPARE, 5));
      add_row(beat_row(rsst_pkg::OP_QUERY, 0, 0, 0, 0, 1, 32'd3));
      add_row(csr_row(rsst_pkg::CSR_ACTIVE_SIZE, 32'hffff_ffff));
      add_row(beat_row(rsst_pkg::OP_ADD, 1023, 32'h1234_5678, 0, 0, 0, 0));
      add_row(beat_row(rsst_pkg::OP_QUERY, 0, 0, 1000, 1023, 1, 32'h1234_5678));
      add_row(beat_row(rsst_pkg::OP_QUERY, 0, 0, 0, 1022, 1, 32'd0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR)
            write_register(plan[i].addr, plan[i].value);
         else
            send_beat(plan[i].op, plan[i].leaf, plan[i].value, plan[i].lo, plan[i].hi,
                      plan[i].fixed, plan[i].sum);
      end

      foreach (phase_sizes[p]) begin
         wdata = ($urandom & 32'hffff_f800) | phase_sizes[p];
         write_register(rsst_pkg::CSR_ACTIVE_SIZE, wdata);
         if (p == 4) write_register(CSR_SPARE, $urandom);
         calm = (p == 6);
         repeat (PHASE_BEATS) random_beat();
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      while (pending_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d adds and %0d queries sent, %0d sums checked, %0d active_size writes",
               adds, queries, sums_checked, size_writes);
      $display("sizes 0 to 2047 incl. clipping, wrap at 32 bits, %0d mismatches, %0d cycles",
               errors, cycles);
      if (errors == 0)
         $display("range_sum_segment_tree regression: pass");
      else
         $display("range_sum_segment_tree regression: fail");
      $finish;
   end

endmodule
